// ===== rtl/rpfc_pkg.sv =====
`timescale 1ns / 1ps

package rpfc_pkg;

    // Result status codes
    localparam logic [2:0] ST_HUNT     = 3'd0;
    localparam logic [2:0] ST_FIRST    = 3'd1;
    localparam logic [2:0] ST_LOCKED   = 3'd2;
    localparam logic [2:0] ST_STORED   = 3'd3;
    localparam logic [2:0] ST_ABORT    = 3'd4;
    localparam logic [2:0] ST_COMPLETE = 3'd5;
    localparam logic [2:0] ST_BUSY     = 3'd6;
    localparam logic [2:0] ST_RELEASED = 3'd7;

    // Input command codes
    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Register word indexes (byte address divided by four)
    localparam logic [2:0] REG_SYNC_LOW     = 3'd0;
    localparam logic [2:0] REG_SYNC_HIGH    = 3'd1;
    localparam logic [2:0] REG_WIDTH_LOW    = 3'd2;
    localparam logic [2:0] REG_WIDTH_HIGH   = 3'd3;
    localparam logic [2:0] REG_FRAME_LENGTH = 3'd4;

    // Field widths
    localparam int WIDTH_W = 16;
    localparam int POS_W   = 10;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register reset values
    localparam logic [WIDTH_W-1:0] SYNC_LOW_RST     = 16'd3000;
    localparam logic [WIDTH_W-1:0] SYNC_HIGH_RST    = 16'd14000;
    localparam logic [WIDTH_W-1:0] WIDTH_LOW_RST    = 16'd150;
    localparam logic [WIDTH_W-1:0] WIDTH_HIGH_RST   = 16'd15000;
    localparam logic [POS_W-1:0]   FRAME_LENGTH_RST = 10'd150;

    typedef struct packed {
        logic [WIDTH_W-1:0] sync_low;
        logic [WIDTH_W-1:0] sync_high;
        logic [WIDTH_W-1:0] width_low;
        logic [WIDTH_W-1:0] width_high;
        logic [POS_W-1:0]   frame_length;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [POS_W-1:0]   index;
        logic [WIDTH_W-1:0] captured_width;
        logic               frame_done;
    } res_t;

endpackage

// ===== rtl/rpfc_regs.sv =====
`timescale 1ns / 1ps

module rpfc_regs
    import rpfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes; addresses beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_low     <= SYNC_LOW_RST;
            cfg_reg.sync_high    <= SYNC_HIGH_RST;
            cfg_reg.width_low    <= WIDTH_LOW_RST;
            cfg_reg.width_high   <= WIDTH_HIGH_RST;
            cfg_reg.frame_length <= FRAME_LENGTH_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_SYNC_LOW:     cfg_reg.sync_low     <= pwdata[WIDTH_W-1:0];
                REG_SYNC_HIGH:    cfg_reg.sync_high    <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_LOW:    cfg_reg.width_low    <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_HIGH:   cfg_reg.width_high   <= pwdata[WIDTH_W-1:0];
                REG_FRAME_LENGTH: cfg_reg.frame_length <= pwdata[POS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read-back multiplexer
    always_comb
    begin
        case (reg_sel)
            REG_SYNC_LOW:     prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_reg.sync_low};
            REG_SYNC_HIGH:    prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_reg.sync_high};
            REG_WIDTH_LOW:    prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_reg.width_low};
            REG_WIDTH_HIGH:   prdata = {{(DATA_W-WIDTH_W){1'b0}}, cfg_reg.width_high};
            REG_FRAME_LENGTH: prdata = {{(DATA_W-POS_W){1'b0}}, cfg_reg.frame_length};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/rpfc_core.sv =====
`timescale 1ns / 1ps

module rpfc_core
    import rpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               cmd,
    input  logic [WIDTH_W-1:0] pulse_width,
    input  cfg_t               cfg,
    output res_t               res
);

    logic             hunting_reg;
    logic             hunting_next;
    logic             sync_seen_reg;
    logic             sync_seen_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic             done_flag_reg;
    logic             done_flag_next;
    logic             is_sync;
    logic             out_of_range;
    logic [POS_W-1:0] pos_inc;

    assign is_sync      = (pulse_width > cfg.sync_low) && (pulse_width < cfg.sync_high);
    assign out_of_range = (pulse_width < cfg.width_low) || (pulse_width > cfg.width_high);
    assign pos_inc      = position_reg + 1'b1;

    // Next state and the result word for the presented item
    always_comb
    begin
        hunting_next       = hunting_reg;
        sync_seen_next     = sync_seen_reg;
        position_next      = position_reg;
        done_flag_next     = done_flag_reg;
        res.status         = ST_HUNT;
        res.index          = '0;
        res.captured_width = '0;
        if (cmd == CMD_RELEASE)
        begin
            if (done_flag_reg)
            begin
                done_flag_next = 1'b0;
                position_next  = '0;
            end
            res.status = ST_RELEASED;
        end
        else if (done_flag_reg)
        begin
            res.status = ST_BUSY;
        end
        else if (hunting_reg)
        begin
            if (is_sync)
            begin
                if (!sync_seen_reg)
                begin
                    sync_seen_next = 1'b1;
                    res.status     = ST_FIRST;
                end
                else
                begin
                    // Second sync locks the frame and becomes element zero
                    sync_seen_next     = 1'b0;
                    hunting_next       = 1'b0;
                    position_next      = {{(POS_W-1){1'b0}}, 1'b1};
                    res.captured_width = pulse_width;
                    res.status         = ST_LOCKED;
                end
            end
        end
        else
        begin
            res.index          = position_reg;
            res.captured_width = pulse_width;
            if (out_of_range)
            begin
                hunting_next  = 1'b1;
                position_next = '0;
                res.status    = ST_ABORT;
            end
            else
            begin
                position_next = pos_inc;
                if (pos_inc >= cfg.frame_length)
                begin
                    done_flag_next = 1'b1;
                    hunting_next   = 1'b1;
                    res.status     = ST_COMPLETE;
                end
                else
                begin
                    res.status = ST_STORED;
                end
            end
        end
        res.frame_done = done_flag_next;
    end

    // Frame state advances only when a word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg   <= 1'b1;
            sync_seen_reg <= 1'b0;
            position_reg  <= '0;
            done_flag_reg <= 1'b0;
        end
        else if (take)
        begin
            hunting_reg   <= hunting_next;
            sync_seen_reg <= sync_seen_next;
            position_reg  <= position_next;
            done_flag_reg <= done_flag_next;
        end
    end

    // A finished frame always leaves the block hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        done_flag_reg |-> hunting_reg)
        else $error("frame done while not hunting");

    // The first-sync mark is only kept while hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        !hunting_reg |-> !sync_seen_reg)
        else $error("sync mark held during capture");

    // A completed frame raises the done flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.status == ST_COMPLETE) |=> done_flag_reg)
        else $error("completion did not set done flag");

    // A locked frame starts storing at position one
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && res.status == ST_LOCKED) |=> (position_reg == 1 && !hunting_reg))
        else $error("lock did not start the frame");

endmodule

// ===== rtl/rpfc_out_stage.sv =====
`timescale 1ns / 1ps

module rpfc_out_stage
    import rpfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic out_stall,
    output logic out_valid,
    output logic in_stall,
    output res_t res_out
);

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    // The stage takes a new word whenever it is empty or being emptied
    assign in_stall       = out_valid_reg & out_stall;
    assign out_valid_next = load | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;
    assign res_out        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    // A word is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/rf_pulse_frame_capture_unit.sv =====
`timescale 1ns / 1ps

// Radio pulse frame capture.
// Input channel: one word per signal edge (cmd = 0, pulse_width in timer ticks)
// or a release command (cmd = 1), moved on in_valid with in_stall low.
// Output channel: exactly one result word per input word, in order, moved on
// out_valid with out_stall low: status, index, captured_width, frame_done.
// The result of a word is registered and offered in the cycle after it is taken.
// Throughput is one word per cycle when the receiver does not stall; the frame
// state is updated by a few compares and a position increment; the result word
// sits in a single result register. When the receiver stalls, that register
// holds its word and in_stall is raised, so at most one word waits; the word
// is freed in the cycle it is taken and a new input is accepted that same cycle.
// Reset empties the result register and returns the frame logic to hunting
// with no sync seen, position zero and no frame pending; the thresholds and
// frame length return to their defaults. Registers are written over the APB
// port and should only be changed while no word is in flight.

module rf_pulse_frame_capture_unit
    import rpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [WIDTH_W-1:0] pulse_width,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [POS_W-1:0]   index,
    output logic [WIDTH_W-1:0] captured_width,
    output logic               frame_done
);

    cfg_t cfg;
    res_t res_comb;
    res_t res_held;
    logic take;

    assign take = in_valid & ~in_stall;

    rpfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpfc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .cmd         (cmd),
        .pulse_width (pulse_width),
        .cfg         (cfg),
        .res         (res_comb)
    );

    rpfc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (res_comb),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .in_stall  (in_stall),
        .res_out   (res_held)
    );

    assign status         = res_held.status;
    assign index          = res_held.index;
    assign captured_width = res_held.captured_width;
    assign frame_done     = res_held.frame_done;

endmodule

// ===== sim/frame_capture_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both word channels of the pulse frame
// capture unit. It keeps its own copy of the frame state and thresholds,
// works out the result word for every accepted input word, and compares each
// accepted result word with the oldest one still waiting.
module frame_capture_checker
    import rpfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               cmd,
    input  logic [WIDTH_W-1:0] pulse_width,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         status,
    input  logic [POS_W-1:0]   index,
    input  logic [WIDTH_W-1:0] captured_width,
    input  logic               frame_done,
    output int                 fail_count,
    output int                 outstanding
);

    cfg_t             thresholds;
    logic             hunting;
    logic             sync_seen;
    logic             done_flag;
    logic [POS_W-1:0] position;
    res_t             pending_results[$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Advance the frame state by one input word and return its result word.
    function automatic res_t capture_step(input logic c, input logic [WIDTH_W-1:0] w);
        res_t r;
        r = '0;
        if (c == CMD_RELEASE)
        begin
            if (done_flag)
            begin
                done_flag = 1'b0;
                position  = '0;
            end
            r.status = ST_RELEASED;
        end
        else if (done_flag)
        begin
            r.status = ST_BUSY;
        end
        else if (hunting)
        begin
            if (w > thresholds.sync_low && w < thresholds.sync_high)
            begin
                if (!sync_seen)
                begin
                    sync_seen = 1'b1;
                    r.status  = ST_FIRST;
                end
                else
                begin
                    // Second sync width is element zero of the frame.
                    sync_seen        = 1'b0;
                    hunting          = 1'b0;
                    position         = 10'd1;
                    r.captured_width = w;
                    r.status         = ST_LOCKED;
                end
            end
            else
            begin
                r.status = ST_HUNT;
            end
        end
        else
        begin
            r.index          = position;
            r.captured_width = w;
            if (w < thresholds.width_low || w > thresholds.width_high)
            begin
                hunting  = 1'b1;
                position = '0;
                r.status = ST_ABORT;
            end
            else
            begin
                position = position + 1'b1;
                if (position >= thresholds.frame_length)
                begin
                    done_flag = 1'b1;
                    hunting   = 1'b1;
                    r.status  = ST_COMPLETE;
                end
                else
                begin
                    r.status = ST_STORED;
                end
            end
        end
        r.frame_done = done_flag;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WIDTH_W-1:0] want,
                               input logic [WIDTH_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare first, then predict: a word taken at this edge cannot have its
    // result offered at the same edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            thresholds = '{sync_low: SYNC_LOW_RST, sync_high: SYNC_HIGH_RST,
                           width_low: WIDTH_LOW_RST, width_high: WIDTH_HIGH_RST,
                           frame_length: FRAME_LENGTH_RST};
            hunting   = 1'b1;
            sync_seen = 1'b0;
            done_flag = 1'b0;
            position  = '0;
            pending_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, status %0d index %0d",
                             $time, status, index);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("index", 16'(want.index), 16'(index));
                    check_field("captured_width", want.captured_width, captured_width);
                    check_field("frame_done", 16'(want.frame_done), 16'(frame_done));
                end
            end

            if (in_valid && !in_stall)
                pending_results.push_back(capture_step(cmd, pulse_width));

            // Register writes land at the access cycle.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SYNC_LOW:     thresholds.sync_low     = pwdata[WIDTH_W-1:0];
                    REG_SYNC_HIGH:    thresholds.sync_high    = pwdata[WIDTH_W-1:0];
                    REG_WIDTH_LOW:    thresholds.width_low    = pwdata[WIDTH_W-1:0];
                    REG_WIDTH_HIGH:   thresholds.width_high   = pwdata[WIDTH_W-1:0];
                    REG_FRAME_LENGTH: thresholds.frame_length = pwdata[POS_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rpfc_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               cmd         = CMD_EDGE;
    logic [WIDTH_W-1:0] pulse_width = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [2:0]         status;
    logic [POS_W-1:0]   index;
    logic [WIDTH_W-1:0] captured_width;
    logic               frame_done;

    int   fail_count;
    int   outstanding;
    int   quiet_cycles  = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   words_sent    = 0;
    int   phase_target  = 0;
    cfg_t cur_cfg;

    int idle_modes[4]  = '{0, 56, 0, 23};
    int stall_modes[4] = '{0, 0, 56, 23};

    rf_pulse_frame_capture_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .pulse_width    (pulse_width),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .index          (index),
        .captured_width (captured_width),
        .frame_done     (frame_done)
    );

    frame_capture_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .pulse_width    (pulse_width),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .index          (index),
        .captured_width (captured_width),
        .frame_done     (frame_done),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always #1 clk = ~clk;

    // Receiver stalls at random, independent of out_valid.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // End the run if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one word, after random idle cycles, and hold it until taken.
    task automatic send_word(input logic c, input logic [WIDTH_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        pulse_width <= w;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // Stop sending and wait until every expected result word has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // APB write: setup phase, access phase, then the bus returns to idle.
    // Bits above the register width carry random junk.
    task automatic write_reg(input logic [2:0] reg_idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] keep;
        keep    = (reg_idx == REG_FRAME_LENGTH) ? 32'h3FF : 32'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= (value & keep) | ($urandom & ~keep);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (reg_idx)
            REG_SYNC_LOW:     cur_cfg.sync_low     = value[WIDTH_W-1:0];
            REG_SYNC_HIGH:    cur_cfg.sync_high    = value[WIDTH_W-1:0];
            REG_WIDTH_LOW:    cur_cfg.width_low    = value[WIDTH_W-1:0];
            REG_WIDTH_HIGH:   cur_cfg.width_high   = value[WIDTH_W-1:0];
            REG_FRAME_LENGTH: cur_cfg.frame_length = value[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input int sl, input int sh, input int wl, input int wh,
                               input int fl);
        drain_results();
        write_reg(REG_SYNC_LOW, sl);
        write_reg(REG_SYNC_HIGH, sh);
        write_reg(REG_WIDTH_LOW, wl);
        write_reg(REG_WIDTH_HIGH, wh);
        write_reg(REG_FRAME_LENGTH, fl);
    endtask

    task automatic set_pressure(input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     <= stall;
    endtask

    function automatic logic [WIDTH_W-1:0] sync_width();
        int lo, hi;
        lo = cur_cfg.sync_low;
        hi = cur_cfg.sync_high;
        if (hi > lo + 1)
            return WIDTH_W'($urandom_range(lo + 1, hi - 1));
        return WIDTH_W'($urandom);
    endfunction

    function automatic logic [WIDTH_W-1:0] data_width();
        int lo, hi;
        lo = cur_cfg.width_low;
        hi = cur_cfg.width_high;
        if (hi >= lo)
            return WIDTH_W'($urandom_range(lo, hi));
        return WIDTH_W'($urandom);
    endfunction

    function automatic logic [WIDTH_W-1:0] bad_width();
        int lo, hi;
        lo = cur_cfg.width_low;
        hi = cur_cfg.width_high;
        if (lo > 0 && (hi == 65535 || $urandom_range(1) == 0))
            return WIDTH_W'($urandom_range(0, lo - 1));
        if (hi < 65535)
            return WIDTH_W'($urandom_range(hi + 1, 65535));
        return WIDTH_W'($urandom);
    endfunction

    // One frame attempt: some noise, a sync pair, data words with the odd
    // abort, a few edges while the frame waits, and usually a release.
    task automatic run_frame();
        int fl;
        int n;
        repeat ($urandom_range(0, 2))
            send_word(($urandom_range(9) == 0) ? CMD_RELEASE : CMD_EDGE, WIDTH_W'($urandom));
        send_word(CMD_EDGE, sync_width());
        if ($urandom_range(4) == 0)
            send_word(CMD_EDGE, WIDTH_W'($urandom));
        send_word(CMD_EDGE, sync_width());
        fl = (cur_cfg.frame_length == 0) ? 1 : cur_cfg.frame_length;
        for (n = 1; n < fl && words_sent < phase_target; n++)
        begin
            if ($urandom_range(99) < 6)
            begin
                send_word(CMD_EDGE, bad_width());
                return;
            end
            send_word(CMD_EDGE, data_width());
        end
        repeat ($urandom_range(0, 2))
            send_word(CMD_EDGE, WIDTH_W'($urandom));
        if ($urandom_range(9) != 0)
            send_word(CMD_RELEASE, WIDTH_W'($urandom));
    endtask

    task automatic run_phase(input int words);
        phase_target = words_sent + words;
        while (words_sent < phase_target)
            run_frame();
    endtask

    initial
    begin : stimulus
        int p;
        int sl, wl;
        cur_cfg = '{sync_low: SYNC_LOW_RST, sync_high: SYNC_HIGH_RST,
                    width_low: WIDTH_LOW_RST, width_high: WIDTH_HIGH_RST,
                    frame_length: FRAME_LENGTH_RST};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: default thresholds, three-word frames.
        set_pressure(0, 0);
        load_config(SYNC_LOW_RST, SYNC_HIGH_RST, WIDTH_LOW_RST, WIDTH_HIGH_RST, 3);
        send_word(CMD_RELEASE, 16'hFFFF);   // release with nothing pending
        send_word(CMD_EDGE, 16'd0);
        send_word(CMD_EDGE, 16'hFFFF);
        send_word(CMD_EDGE, 16'd3000);      // on the lower sync bound, not a sync
        send_word(CMD_EDGE, 16'd3001);      // first sync
        send_word(CMD_EDGE, 16'd14000);     // skipped, first sync kept
        send_word(CMD_EDGE, 16'd13999);     // lock
        send_word(CMD_EDGE, 16'd149);       // below the data floor: abort
        send_word(CMD_EDGE, 16'd5000);
        send_word(CMD_EDGE, 16'd5000);
        send_word(CMD_EDGE, 16'd150);
        send_word(CMD_EDGE, 16'd15000);     // frame complete
        send_word(CMD_EDGE, 16'd7000);      // ignored while the frame waits
        send_word(CMD_RELEASE, 16'd0);
        send_word(CMD_EDGE, 16'd15001);
        send_word(CMD_EDGE, 16'd4000);
        send_word(CMD_EDGE, 16'd4000);
        send_word(CMD_EDGE, 16'd200);
        // Shorten the frame mid-way: the next stored word completes it.
        drain_results();
        write_reg(REG_FRAME_LENGTH, 1);
        send_word(CMD_EDGE, 16'd300);
        send_word(CMD_RELEASE, 16'd0);
        // A frame length of zero behaves as one.
        drain_results();
        write_reg(REG_FRAME_LENGTH, 0);
        send_word(CMD_EDGE, 16'd4000);
        send_word(CMD_EDGE, 16'd4000);
        send_word(CMD_EDGE, 16'd500);
        send_word(CMD_RELEASE, 16'd0);
        // Length one: lock stores element zero, then a too-wide word aborts.
        drain_results();
        write_reg(REG_FRAME_LENGTH, 1);
        send_word(CMD_EDGE, 16'd4000);
        send_word(CMD_EDGE, 16'd4000);
        send_word(CMD_EDGE, 16'hFFFF);

        // Everything open, frame length one.
        load_config(0, 65535, 0, 65535, 1);
        run_phase(120);

        // Random thresholds with short frames, cycling through idle and stall patterns.
        for (p = 0; p < 6; p++)
        begin
            sl = $urandom_range(0, 20000);
            wl = $urandom_range(0, 3000);
            load_config(sl, sl + $urandom_range(2, 20000), wl, wl + $urandom_range(0, 20000),
                        $urandom_range(1, 12));
            set_pressure(idle_modes[p % 4], stall_modes[p % 4]);
            run_phase(130);
        end

        // Everything closed: no sync is possible and every data word aborts.
        load_config(65535, 0, 65535, 0, 1);
        set_pressure(idle_modes[3], stall_modes[3]);
        run_phase(40);

        // Longest frame, which this run never fills.
        load_config(0, 65535, 0, 65535, 1023);
        set_pressure(idle_modes[1], stall_modes[1]);
        run_phase(80);

        drain_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
